FILE: sv/cpr_pkg.sv
`default_nettype none
package cpr_pkg;

  localparam int NUM_FRAMES  = 64;
  localparam int HAND_W      = $clog2(NUM_FRAMES);
  localparam int OFFSET_BITS = 11;
  localparam int ADDR_W      = 32;
  localparam int PAGE_W      = 21;
  localparam int CNT_W       = 32;
  localparam int CFG_W       = 7;

  typedef enum logic [1:0] {
    KIND_FETCH  = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_STORE  = 2'd2,
    KIND_MODIFY = 2'd3
  } cpr_kind_t;

  // Broadcast command from the controller to every frame cell
  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic              writes;
    logic              look;
    logic              fill;
    logic              step;
    logic              restart;
    logic [HAND_W-1:0] fill_idx;
    logic [CFG_W-1:0]  n_act;
  } cpr_cmd_t;

  // Status one cell reports back to the controller
  typedef struct packed {
    logic              match;
    logic              pass;
    logic              wrap;
    logic              beyond;
    logic              victim;
    logic              dirty_sel;
    logic [PAGE_W-1:0] page_sel;
  } cpr_stat_t;

endpackage
`default_nettype wire

FILE: sv/cpr_cell.sv
`default_nettype none
module cpr_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [cpr_pkg::HAND_W-1:0] cell_idx,
  input  wire cpr_pkg::cpr_cmd_t          cmd,
  input  wire logic                      tok_in,
  output cpr_pkg::cpr_stat_t              stat
);

  logic [cpr_pkg::PAGE_W-1:0] page_r, page_nxt;
  logic valid_r, valid_nxt;
  logic ref_r, ref_nxt;
  logic dirty_r, dirty_nxt;
  logic tok_r, tok_nxt;
  logic match, active, last, fill_me, first;

  // Compare against the broadcast page and place this frame in the active range
  assign match   = valid_r && (page_r == cmd.page);
  assign active  = {1'b0, cell_idx} < cmd.n_act;
  assign last    = {1'b0, cell_idx} == (cmd.n_act - cpr_pkg::CFG_W'(1));
  assign fill_me = cmd.fill && (cell_idx == cmd.fill_idx);
  assign first   = (cell_idx == '0);

  // Report status; the hand token holder drives its page onto the OR bus
  always_comb begin
    stat.match     = match;
    stat.pass      = tok_r & ~last;
    stat.wrap      = tok_r & last;
    stat.beyond    = tok_r & ~active;
    stat.victim    = tok_r & ~ref_r;
    stat.dirty_sel = tok_r & dirty_r;
    stat.page_sel  = tok_r ? page_r : '0;
  end

  // Update the frame: mark on hit, fill, sweep step, hand restart
  always_comb begin
    page_nxt  = page_r;
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    dirty_nxt = dirty_r;
    tok_nxt   = tok_r;
    if (cmd.look && match) begin
      ref_nxt = 1'b1;
      if (cmd.writes) begin
        dirty_nxt = 1'b1;
      end
    end
    if (fill_me) begin
      page_nxt  = cmd.page;
      valid_nxt = 1'b1;
      ref_nxt   = 1'b1;
      dirty_nxt = cmd.writes;
    end
    if (cmd.restart) begin
      tok_nxt = first;
    end
    if (cmd.step) begin
      tok_nxt = tok_in;
      if (tok_r) begin
        if (ref_r) begin
          ref_nxt = 1'b0;
        end else begin
          page_nxt  = cmd.page;
          valid_nxt = 1'b1;
          ref_nxt   = 1'b1;
          dirty_nxt = cmd.writes;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ref_r   <= 1'b0;
      dirty_r <= 1'b0;
      tok_r   <= first;
    end else begin
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
      dirty_r <= dirty_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Page number needs no reset; it is read only once the frame is valid
  always_ff @(posedge clk) begin
    page_r <= page_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/clock_page_replacement_core.sv
`default_nettype none
// Clock (second-chance) page replacement core.
// Input channel in_valid/in_ready carries one access word: in_access_kind
// (fetch, load, store, modify) and in_address; the page is address >> 11.
// Output channel out_valid/out_ready returns one result word per access:
// hit, evicted, evicted_page, write_back and the three running totals.
// Config channel cfg_valid/cfg_ready writes frames_in_use (always ready);
// write it only while no access is in flight.
// Frames sit in a row of 64 cells; each compares its page in parallel and the
// clock hand is a token passed from cell to neighbor, one frame per cycle.
// Each access passes from LOOK to DONE on a hit, through FILL on a miss that fills
// a free frame, and through SWEEP on a replacement, where the hand token visits
// 1 to frames+1 frames. One access is in work at a time; with out_ready high a
// new access is taken as soon as the previous one has reached the output register.
// If the receiver stalls with a result still held, the next access finishes
// and waits in the core until the output register frees up.
// Reset (rst_n low, synchronous) empties all frames, puts the hand on frame 0,
// clears the totals and sets frames_in_use to 64.
module clock_page_replacement_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output      logic                         in_ready,
  input  wire logic [1:0]                   in_access_kind,
  input  wire logic [cpr_pkg::ADDR_W-1:0]   in_address,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic                         out_hit,
  output      logic                         out_evicted,
  output      logic [cpr_pkg::PAGE_W-1:0]   out_evicted_page,
  output      logic                         out_write_back,
  output      logic [cpr_pkg::CNT_W-1:0]    out_fault_total,
  output      logic [cpr_pkg::CNT_W-1:0]    out_write_total,
  output      logic [cpr_pkg::CNT_W-1:0]    out_access_total,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [cpr_pkg::CFG_W-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOOK  = 5'b00010,
    ST_FILL  = 5'b00100,
    ST_SWEEP = 5'b01000,
    ST_DONE  = 5'b10000
  } cpr_state_t;

  localparam int NF = cpr_pkg::NUM_FRAMES;

  function automatic logic [cpr_pkg::CNT_W-1:0] sat_add(
    input logic [cpr_pkg::CNT_W-1:0] a,
    input logic [1:0]                b
  );
    logic [cpr_pkg::CNT_W:0] s;
    s = {1'b0, a} + (cpr_pkg::CNT_W+1)'(b);
    return s[cpr_pkg::CNT_W] ? '1 : s[cpr_pkg::CNT_W-1:0];
  endfunction

  cpr_state_t state_r, state_nxt;

  logic [cpr_pkg::CFG_W-1:0]  frames_cfg_r;
  logic [cpr_pkg::CFG_W-1:0]  n_act;
  logic [cpr_pkg::CFG_W-1:0]  filled_r;
  logic [1:0]                 kind_r;
  logic [cpr_pkg::PAGE_W-1:0] page_r;
  logic                       hit_r, ev_r, wb_r;
  logic [cpr_pkg::PAGE_W-1:0] ev_page_r;
  logic [cpr_pkg::CNT_W-1:0]  fault_cnt_r, wb_cnt_r, acc_cnt_r;
  logic                       out_valid_r, out_hit_r, out_ev_r, out_wb_r;
  logic [cpr_pkg::PAGE_W-1:0] out_ev_page_r;
  logic [cpr_pkg::CNT_W-1:0]  out_fault_r, out_wbt_r, out_acc_r;

  cpr_pkg::cpr_cmd_t  cmd;
  cpr_pkg::cpr_stat_t stat [NF];
  logic [NF-1:0]      tok_in;

  logic                       any_hit, any_beyond, any_victim, any_dirty, any_wrap;
  logic [cpr_pkg::PAGE_W-1:0] sel_page;
  logic                       full, writes, accept_in, load_out;

  // Clamp the configured frame count into 1..NUM_FRAMES
  always_comb begin
    if (frames_cfg_r == '0) begin
      n_act = cpr_pkg::CFG_W'(1);
    end else if (frames_cfg_r > cpr_pkg::CFG_W'(NF)) begin
      n_act = cpr_pkg::CFG_W'(NF);
    end else begin
      n_act = frames_cfg_r;
    end
  end

  assign full      = filled_r >= n_act;
  assign writes    = (kind_r == cpr_pkg::KIND_STORE) || (kind_r == cpr_pkg::KIND_MODIFY);
  assign in_ready  = (state_r == ST_IDLE);
  assign accept_in = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Gather cell status over the row
  always_comb begin
    any_hit    = 1'b0;
    any_beyond = 1'b0;
    any_victim = 1'b0;
    any_dirty  = 1'b0;
    any_wrap   = 1'b0;
    sel_page   = '0;
    for (int i = 0; i < NF; i++) begin
      any_hit    = any_hit | stat[i].match;
      any_beyond = any_beyond | stat[i].beyond;
      any_victim = any_victim | stat[i].victim;
      any_dirty  = any_dirty | stat[i].dirty_sel;
      any_wrap   = any_wrap | stat[i].wrap;
      sel_page   = sel_page | stat[i].page_sel;
    end
  end

  // Broadcast command to the cells
  always_comb begin
    cmd.page     = page_r;
    cmd.writes   = writes;
    cmd.look     = (state_r == ST_LOOK);
    cmd.fill     = (state_r == ST_FILL);
    cmd.step     = (state_r == ST_SWEEP);
    cmd.restart  = (state_r == ST_LOOK) && !any_hit && full && any_beyond;
    cmd.fill_idx = filled_r[cpr_pkg::HAND_W-1:0];
    cmd.n_act    = n_act;
  end

  // Build the frame row; the token wraps from the last active frame to frame 0
  genvar g;
  generate
    for (g = 0; g < NF; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign tok_in[g] = any_wrap;
      end else begin : g_rest
        assign tok_in[g] = stat[g-1].pass;
      end
      cpr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (cpr_pkg::HAND_W'(g)),
        .cmd      (cmd),
        .tok_in   (tok_in[g]),
        .stat     (stat[g])
      );
    end
  endgenerate

  // Sequence one access
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_in) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (any_hit) begin
          state_nxt = ST_DONE;
        end else if (!full) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_FILL: state_nxt = ST_DONE;
      ST_SWEEP: begin
        if (any_victim) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      frames_cfg_r <= cpr_pkg::CFG_W'(NF);
      filled_r     <= '0;
      fault_cnt_r  <= '0;
      wb_cnt_r     <= '0;
      acc_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        frames_cfg_r <= cfg_data;
      end
      if (state_r == ST_LOOK) begin
        acc_cnt_r <= sat_add(acc_cnt_r,
                             (kind_r == cpr_pkg::KIND_MODIFY) ? 2'd2 : 2'd1);
        if (!any_hit) begin
          fault_cnt_r <= sat_add(fault_cnt_r, 2'd1);
        end
      end
      if (state_r == ST_FILL) begin
        filled_r <= filled_r + cpr_pkg::CFG_W'(1);
      end
      if (state_r == ST_SWEEP && any_victim && any_dirty) begin
        wb_cnt_r <= sat_add(wb_cnt_r, 2'd1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Access word and per-access result
  always_ff @(posedge clk) begin
    if (accept_in) begin
      kind_r    <= in_access_kind;
      page_r    <= in_address[cpr_pkg::ADDR_W-1:cpr_pkg::OFFSET_BITS];
      ev_r      <= 1'b0;
      wb_r      <= 1'b0;
      ev_page_r <= '0;
    end
    if (state_r == ST_LOOK) begin
      hit_r <= any_hit;
    end
    if (state_r == ST_SWEEP && any_victim) begin
      ev_r      <= 1'b1;
      wb_r      <= any_dirty;
      ev_page_r <= sel_page;
    end
    if (load_out) begin
      out_hit_r     <= hit_r;
      out_ev_r      <= ev_r;
      out_ev_page_r <= ev_page_r;
      out_wb_r      <= wb_r;
      out_fault_r   <= fault_cnt_r;
      out_wbt_r     <= wb_cnt_r;
      out_acc_r     <= acc_cnt_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_evicted      = out_ev_r;
  assign out_evicted_page = out_ev_page_r;
  assign out_write_back   = out_wb_r;
  assign out_fault_total  = out_fault_r;
  assign out_write_total  = out_wbt_r;
  assign out_access_total = out_acc_r;

endmodule
`default_nettype wire
